@@ src/mtd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtd_pkg: shared types and tables of the morse text decoder
// payload structs, the token entry passed from front to back, character
// constants and the letter/digit code table with its lookup function
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [2:0] LEN_SAT  = 3'd6;
  localparam logic [2:0] LEN_MAX  = 3'd5;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int         NUM_CODES = 36;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_text;
  } out_item_t;

  // one finished token, as handed from the front to the back
  typedef struct packed {
    logic [2:0] length;
    logic [4:0] pattern;
    logic       bad;
    logic       slash;
    logic       last;
  } tok_entry_t;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
    logic [7:0] ch;
  } code_t;

  localparam code_t CODE_TABLE [NUM_CODES] = '{
    '{3'd2, 5'd1,  "A"}, '{3'd4, 5'd8,  "B"}, '{3'd4, 5'd10, "C"},
    '{3'd3, 5'd4,  "D"}, '{3'd1, 5'd0,  "E"}, '{3'd4, 5'd2,  "F"},
    '{3'd3, 5'd6,  "G"}, '{3'd4, 5'd0,  "H"}, '{3'd2, 5'd0,  "I"},
    '{3'd4, 5'd7,  "J"}, '{3'd3, 5'd5,  "K"}, '{3'd4, 5'd4,  "L"},
    '{3'd2, 5'd3,  "M"}, '{3'd2, 5'd2,  "N"}, '{3'd3, 5'd7,  "O"},
    '{3'd4, 5'd6,  "P"}, '{3'd4, 5'd13, "Q"}, '{3'd3, 5'd2,  "R"},
    '{3'd3, 5'd0,  "S"}, '{3'd1, 5'd1,  "T"}, '{3'd3, 5'd1,  "U"},
    '{3'd4, 5'd1,  "V"}, '{3'd3, 5'd3,  "W"}, '{3'd4, 5'd9,  "X"},
    '{3'd4, 5'd11, "Y"}, '{3'd4, 5'd12, "Z"},
    '{3'd5, 5'd31, "0"}, '{3'd5, 5'd15, "1"}, '{3'd5, 5'd7,  "2"},
    '{3'd5, 5'd3,  "3"}, '{3'd5, 5'd1,  "4"}, '{3'd5, 5'd0,  "5"},
    '{3'd5, 5'd16, "6"}, '{3'd5, 5'd24, "7"}, '{3'd5, 5'd28, "8"},
    '{3'd5, 5'd30, "9"}
  };

  function automatic logic [7:0] decode_token(tok_entry_t e);
    logic [7:0] ch;
    ch = CH_QMARK;
    if (e.slash) begin
      ch = (e.length == 3'd1 && !e.bad) ? CH_SPACE : CH_QMARK;
    end else if (!e.bad && e.length <= LEN_MAX) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        if (CODE_TABLE[i].len == e.length && CODE_TABLE[i].pat == e.pattern) begin
          ch = CODE_TABLE[i].ch;
        end
      end
    end
    return ch;
  endfunction

endpackage

@@ src/morse_text_decoder_top.sv @@
// ----------------------------------------------------------------------------
// morse_text_decoder_top: the result of the beat that ends a token reaches
// out_data through the token queue and then the output register; one input
// beat per cycle while the receiver keeps up, the input stalls only when the
// token queue is full
// reset clears the pending token, the queue and the output valid flag
// ----------------------------------------------------------------------------
module morse_text_decoder_top
  import mtd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  tok_entry_t q_entry;
  tok_entry_t q_head;

  mtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  mtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  mtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ src/mtd_front.sv @@
// ----------------------------------------------------------------------------
// mtd_front: character intake and token builder
// classifies each byte, gathers dots and dashes into the pending token and
// pushes a finished token entry into the queue at whitespace or last
// ----------------------------------------------------------------------------
module mtd_front
  import mtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       q_full,
  output logic       q_push,
  output tok_entry_t q_entry
);

  logic [2:0] length_r,  length_nxt;
  logic [4:0] pattern_r, pattern_nxt;
  logic       bad_r,     bad_nxt;
  logic       slash_r,   slash_nxt;

  logic [2:0] t_length;
  logic [4:0] t_pattern;
  logic       t_bad;
  logic       t_slash;
  logic       is_space;
  logic       token_end;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_space = (in_data.text_char == CH_SPACE) ||
               (in_data.text_char >= CH_TAB && in_data.text_char <= CH_CR);

    t_length  = length_r;
    t_pattern = pattern_r;
    t_bad     = bad_r;
    t_slash   = slash_r;
    if (!is_space) begin
      if (in_data.text_char == CH_DOT || in_data.text_char == CH_DASH) begin
        t_pattern = {pattern_r[3:0], in_data.text_char == CH_DASH};
      end else if (in_data.text_char == CH_SLASH) begin
        if (length_r == 3'd0) begin
          t_slash = 1'b1;
        end else begin
          t_bad = 1'b1;
        end
      end else begin
        t_bad = 1'b1;
      end
      if (length_r < LEN_SAT) begin
        t_length = length_r + 3'd1;
      end
    end

    token_end = is_space || in_data.is_last;

    // an empty token only makes a result when it closes the text
    q_push = accept && token_end && (t_length != 3'd0 || in_data.is_last);
    q_entry.length  = t_length;
    q_entry.pattern = t_pattern;
    q_entry.bad     = t_bad;
    q_entry.slash   = t_slash;
    q_entry.last    = in_data.is_last;

    length_nxt  = length_r;
    pattern_nxt = pattern_r;
    bad_nxt     = bad_r;
    slash_nxt   = slash_r;
    if (accept) begin
      if (token_end) begin
        length_nxt  = 3'd0;
        pattern_nxt = 5'd0;
        bad_nxt     = 1'b0;
        slash_nxt   = 1'b0;
      end else begin
        length_nxt  = t_length;
        pattern_nxt = t_pattern;
        bad_nxt     = t_bad;
        slash_nxt   = t_slash;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r  <= 3'd0;
      pattern_r <= 5'd0;
      bad_r     <= 1'b0;
      slash_r   <= 1'b0;
    end else begin
      length_r  <= length_nxt;
      pattern_r <= pattern_nxt;
      bad_r     <= bad_nxt;
      slash_r   <= slash_nxt;
    end
  end

endmodule

@@ src/mtd_queue.sv @@
// ----------------------------------------------------------------------------
// mtd_queue: token queue between front and back
// small circular buffer of finished token entries with a fill count
// ----------------------------------------------------------------------------
module mtd_queue
  import mtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_entry_t push_entry,
  input  logic       pop,
  output tok_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tok_entry_t       store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/mtd_back.sv @@
// ----------------------------------------------------------------------------
// mtd_back: token decode and result register
// takes the queue head, looks the token up in the code table and holds the
// result in the output register until it is taken
// ----------------------------------------------------------------------------
module mtd_back
  import mtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tok_entry_t q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      // empty entry: last beat with nothing pending
      if (q_head.length == 3'd0) begin
        out_data_nxt.out_char   = CH_NUL;
        out_data_nxt.char_valid = 1'b0;
      end else begin
        out_data_nxt.out_char   = decode_token(q_head);
        out_data_nxt.char_valid = 1'b1;
      end
      out_data_nxt.end_of_text = q_head.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

@@ verif/morse_text_checker.sv @@
// ----------------------------------------------------------------------------
// morse_text_checker: scoreboard of the morse text decoder
// watches both channels, predicts the decoded character of every token from
// the accepted text beats and compares each result beat field by field
// ----------------------------------------------------------------------------
module morse_text_checker
  import mtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        beats_in,
  output int        chars_out,
  output int        spaces_out,
  output int        unknown_out,
  output int        texts_ended
);

  logic [2:0] tok_len;
  logic [4:0] tok_pat;
  logic       tok_bad;
  logic       tok_slash;
  out_item_t  expected_chars [$];

  int n_fail    = 0;
  int n_waiting = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_space   = 0;
  int n_unknown = 0;
  int n_ended   = 0;

  assign fail_count  = n_fail;
  assign pending     = n_waiting;
  assign beats_in    = n_in;
  assign chars_out   = n_out;
  assign spaces_out  = n_space;
  assign unknown_out = n_unknown;
  assign texts_ended = n_ended;

  // itu letters and digits, dot 0 and dash 1, first symbol in the msb
  function automatic logic [7:0] morse_letter(logic [2:0] len, logic [4:0] pat);
    case ({len, pat})
      {3'd1, 5'd0}:  return "E";  {3'd1, 5'd1}:  return "T";
      {3'd2, 5'd0}:  return "I";  {3'd2, 5'd1}:  return "A";
      {3'd2, 5'd2}:  return "N";  {3'd2, 5'd3}:  return "M";
      {3'd3, 5'd0}:  return "S";  {3'd3, 5'd1}:  return "U";
      {3'd3, 5'd2}:  return "R";  {3'd3, 5'd3}:  return "W";
      {3'd3, 5'd4}:  return "D";  {3'd3, 5'd5}:  return "K";
      {3'd3, 5'd6}:  return "G";  {3'd3, 5'd7}:  return "O";
      {3'd4, 5'd0}:  return "H";  {3'd4, 5'd1}:  return "V";
      {3'd4, 5'd2}:  return "F";  {3'd4, 5'd4}:  return "L";
      {3'd4, 5'd6}:  return "P";  {3'd4, 5'd7}:  return "J";
      {3'd4, 5'd8}:  return "B";  {3'd4, 5'd9}:  return "X";
      {3'd4, 5'd10}: return "C";  {3'd4, 5'd11}: return "Y";
      {3'd4, 5'd12}: return "Z";  {3'd4, 5'd13}: return "Q";
      {3'd5, 5'd0}:  return "5";  {3'd5, 5'd1}:  return "4";
      {3'd5, 5'd3}:  return "3";  {3'd5, 5'd7}:  return "2";
      {3'd5, 5'd15}: return "1";  {3'd5, 5'd16}: return "6";
      {3'd5, 5'd24}: return "7";  {3'd5, 5'd28}: return "8";
      {3'd5, 5'd30}: return "9";  {3'd5, 5'd31}: return "0";
      default:       return CH_QMARK;
    endcase
  endfunction

  function automatic logic [7:0] token_char();
    if (tok_slash) begin
      return (tok_len == 3'd1 && !tok_bad) ? CH_SPACE : CH_QMARK;
    end
    if (tok_bad || tok_len > LEN_MAX) begin
      return CH_QMARK;
    end
    return morse_letter(tok_len, tok_pat);
  endfunction

  task automatic clear_token();
    tok_len   = '0;
    tok_pat   = '0;
    tok_bad   = 1'b0;
    tok_slash = 1'b0;
  endtask

  task automatic take_text_beat(input in_item_t b);
    logic      blank;
    out_item_t r;
    blank = (b.text_char == CH_SPACE) || (b.text_char >= CH_TAB && b.text_char <= CH_CR);
    if (!blank) begin
      if (b.text_char == CH_DOT || b.text_char == CH_DASH) begin
        tok_pat = {tok_pat[3:0], b.text_char == CH_DASH};
      end else if (b.text_char == CH_SLASH) begin
        if (tok_len == 3'd0) begin
          tok_slash = 1'b1;
        end else begin
          tok_bad = 1'b1;
        end
      end else begin
        tok_bad = 1'b1;
      end
      if (tok_len < LEN_SAT) begin
        tok_len = tok_len + 3'd1;
      end
    end
    if (blank || b.is_last) begin
      if (tok_len != 3'd0) begin
        r = '{out_char: token_char(), char_valid: 1'b1, end_of_text: b.is_last};
        if (r.out_char == CH_SPACE) begin
          n_space++;
        end
        if (r.out_char == CH_QMARK) begin
          n_unknown++;
        end
        expected_chars.push_back(r);
        clear_token();
      end else if (b.is_last) begin
        // text ends with nothing pending: an empty end marker
        r = '{out_char: CH_NUL, char_valid: 1'b0, end_of_text: 1'b1};
        expected_chars.push_back(r);
      end
      if (b.is_last) begin
        n_ended++;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      clear_token();
      expected_chars.delete();
    end else begin
      // results first: a beat taken at this edge cannot show up at this edge
      if (out_valid && out_ready) begin
        got = out_data;
        n_out++;
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected result: char %h valid %b eot %b",
                                  got.out_char, got.char_valid, got.end_of_text));
        end else begin
          want = expected_chars.pop_front();
          if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
              got.end_of_text !== want.end_of_text) begin
            note_mismatch($sformatf(
              "mismatch: expected char %h valid %b eot %b, got char %h valid %b eot %b",
              want.out_char, want.char_valid, want.end_of_text,
              got.out_char, got.char_valid, got.end_of_text));
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        take_text_beat(in_data);
      end
    end
    n_waiting = expected_chars.size();
  end

endmodule

@@ verif/morse_text_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// morse_text_decoder_top_tb: testbench of the morse text decoder
// a directed run over letters, lone slashes, bad, long and unknown tokens and
// the end-of-text cases, then random morse text sent in bursts against a
// stalling receiver; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module morse_text_decoder_top_tb;
  import mtd_pkg::*;

  localparam int RANDOM_BEATS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_mode_t;
  typedef enum int {TOK_CODE, TOK_SLASH, TOK_LONG, TOK_NOISY, TOK_JUNK} token_kind_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count, pending, beats_in, chars_out, spaces_out, unknown_out, texts_ended;

  int          cycle_cnt  = 0;
  int          burst_left = 0;
  int          beats_sent = 0;
  int          stall_left = 0;
  ready_mode_t stall_mode = READY_ALWAYS;

  morse_text_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  morse_text_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .beats_in   (beats_in),
    .chars_out  (chars_out),
    .spaces_out (spaces_out),
    .unknown_out(unknown_out),
    .texts_ended(texts_ended)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: the stall mode is picked anew whenever its hold count runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= ready_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
      READY_SELDOM:   out_ready <= ($urandom_range(0, 3) == 0);
      default:        out_ready <= ((cycle_cnt % 7) < 3);
    endcase
  end

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] random_blank();
    int pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  function automatic logic [7:0] random_symbol();
    return $urandom_range(0, 1) ? CH_DASH : CH_DOT;
  endfunction

  // one text beat, called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_char: c, is_last: last};
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    burst_left--;
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // one token of random shape and its separators
  task automatic send_random_token();
    int          pick;
    int          len;
    int          seps;
    logic        end_here;
    logic        last_in_body;
    logic [7:0]  noise;
    token_kind_t kind;
    logic [7:0]  body [$];
    pick = $urandom_range(0, 99);
    kind = (pick < 60) ? TOK_CODE : (pick < 68) ? TOK_SLASH : (pick < 78) ? TOK_LONG :
           (pick < 90) ? TOK_NOISY : TOK_JUNK;
    end_here     = ($urandom_range(0, 39) == 0);
    last_in_body = end_here && $urandom_range(0, 1);
    case (kind)
      TOK_CODE: begin
        len = $urandom_range(1, 5);
        repeat (len) body.push_back(random_symbol());
      end
      TOK_SLASH: begin
        body.push_back(CH_SLASH);
      end
      TOK_LONG: begin
        len = $urandom_range(6, 9);
        repeat (len) body.push_back(random_symbol());
      end
      TOK_NOISY: begin
        len = $urandom_range(1, 5);
        repeat (len) body.push_back(random_symbol());
        noise = 8'($urandom_range(0, 255));
        if (is_blank(noise)) begin
          noise = CH_SLASH;
        end
        body[$urandom_range(0, len - 1)] = noise;
      end
      default: begin
        len = $urandom_range(1, 4);
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    for (int i = 0; i < body.size(); i++) begin
      if (kind == TOK_JUNK) begin
        send_beat(body[i], ($urandom_range(0, 7) == 0));
      end else begin
        send_beat(body[i], last_in_body && (i == body.size() - 1));
      end
    end
    if (!last_in_body) begin
      // now and then no separator, so that tokens run together
      seps = ($urandom_range(0, 19) == 0 && !end_here) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < seps; i++) begin
        send_beat(random_blank(), end_here && (i == seps - 1));
      end
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text(".-", 1'b0);
    send_beat(CH_TAB, 1'b0);
    send_text("/", 1'b0);
    send_beat(8'h0a, 1'b0);
    // blank with nothing pending gives nothing
    send_beat(CH_CR, 1'b0);
    send_text("/. ", 1'b0);
    send_beat(CH_NUL, 1'b0);
    send_beat(8'h0b, 1'b0);
    // six symbols: length saturates
    send_text("--.-.-", 1'b0);
    send_beat(8'h0c, 1'b0);
    // four symbols with no letter behind them
    send_text("..-- ", 1'b0);
    send_beat(CH_SPACE, 1'b1);
    send_beat(CH_DASH, 1'b1);

    pick_random : begin
      int start;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
        send_random_token();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d text beats in, %0d results checked (%0d spaces, %0d unknown)",
             beats_in, chars_out, spaces_out, unknown_out);
    $display("summary: %0d end-of-text beats, %0d cycles", texts_ended, cycle_cnt);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
